>>> src/edt_pkg.sv
package edt_pkg;

  // calendar and time constants
  localparam int unsigned FirstYear  = 1970;
  localparam int unsigned SecsPerDay = 24 * 60 * 60;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin = 60;
  localparam int unsigned LeapDays   = 366;
  localparam int unsigned CommonDays = 365;

  // quotient bit counts for the three divisions
  localparam int unsigned DayQBits  = 16;
  localparam int unsigned HourQBits = 5;
  localparam int unsigned MinQBits  = 6;

  localparam logic [3:0] LastMonth = 4'd11;
  localparam logic [3:0] February  = 4'd1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAYS,
    ST_YEAR,
    ST_MONTH,
    ST_HOUR,
    ST_MINUTE
  } state_t;

  // shared subtract and compare result
  typedef struct packed {
    logic [31:0] diff;
    logic        ge;
  } alu_res_t;

  // control from sequencer to year tracker
  typedef struct packed {
    logic init;
    logic step;
  } yr_ctl_t;

  // month length, zero-based month
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0:    len = 5'd31;
      February: len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> src/edt_alu.sv
module edt_alu (
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output edt_pkg::alu_res_t res
);

  logic [32:0] wide;

  // single subtractor, borrow out gives the compare
  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[31:0];
  assign res.ge   = ~wide[32];

endmodule

>>> src/edt_year.sv
module edt_year (
  input  logic             clk,
  input  edt_pkg::yr_ctl_t ctl,
  output logic [11:0]      year,
  output logic             leap
);

  localparam logic [1:0] Mod4Init   = 2'(edt_pkg::FirstYear % 4);
  localparam logic [6:0] Mod100Init = 7'(edt_pkg::FirstYear % 100);
  localparam logic [8:0] Mod400Init = 9'(edt_pkg::FirstYear % 400);

  logic [1:0] mod4;
  logic [6:0] mod100;
  logic [8:0] mod400;

  // year counter with running residues
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      year   <= 12'(edt_pkg::FirstYear);
      mod4   <= Mod4Init;
      mod100 <= Mod100Init;
      mod400 <= Mod400Init;
    end else if (ctl.step) begin
      year   <= year + 12'd1;
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
    end
  end

  // gregorian leap rule
  assign leap = (mod400 == 9'd0) || ((mod4 == 2'd0) && (mod100 != 7'd0));

endmodule

>>> src/epoch_seconds_to_date_time_unit.sv
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+----------------------
// input    | epoch_seconds                                      | start, taken if !busy
// result   | day_of_month month_number year_number hour_of_day  | done, one cycle
//          | minute_of_hour second_of_minute                    |
//
// busy stays high while the single shared subtractor works through the conversion:
// 16 restoring steps for the day split, one step per year and per month plus a closing
// compare for each, then 5 and 6 steps for hour and minute.
// done rises the cycle after the last step and busy is low in that cycle.
// rst is synchronous and returns the sequencer to idle; the receiver cannot stall.
module epoch_seconds_to_date_time_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  output logic        busy,
  output logic        done,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [11:0] year_number,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  edt_pkg::state_t   state;
  edt_pkg::state_t   state_next;
  edt_pkg::alu_res_t alu_res;
  edt_pkg::yr_ctl_t  yr_ctl;

  logic [31:0] rem;
  logic [31:0] rem_next;
  logic [31:0] operand;
  logic [15:0] q;
  logic [15:0] q_next;
  logic [3:0]  k;
  logic [16:0] tod;
  logic [3:0]  month_cnt;
  logic [4:0]  day_work;
  logic [4:0]  hour_work;
  logic [11:0] year;
  logic        leap;
  logic        accept;
  logic        last_bit;

  assign busy     = (state != edt_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign last_bit = (k == 4'd0);

  edt_alu u_alu (
    .a   (rem),
    .b   (operand),
    .res (alu_res)
  );

  edt_year u_year (
    .clk  (clk),
    .ctl  (yr_ctl),
    .year (year),
    .leap (leap)
  );

  // restoring step shared by all divisions
  always_comb begin
    rem_next = alu_res.ge ? alu_res.diff : rem;
    q_next   = q;
    if (alu_res.ge) begin
      q_next[k] = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      edt_pkg::ST_IDLE: begin
        if (accept) state_next = edt_pkg::ST_DAYS;
      end
      edt_pkg::ST_DAYS: begin
        if (last_bit) state_next = edt_pkg::ST_YEAR;
      end
      edt_pkg::ST_YEAR: begin
        if (!alu_res.ge) state_next = edt_pkg::ST_MONTH;
      end
      edt_pkg::ST_MONTH: begin
        if (!alu_res.ge || month_cnt == edt_pkg::LastMonth) state_next = edt_pkg::ST_HOUR;
      end
      edt_pkg::ST_HOUR: begin
        if (last_bit) state_next = edt_pkg::ST_MINUTE;
      end
      edt_pkg::ST_MINUTE: begin
        if (last_bit) state_next = edt_pkg::ST_IDLE;
      end
      default: state_next = edt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: subtrahend select and year control
  always_comb begin
    operand     = '0;
    yr_ctl.init = 1'b0;
    yr_ctl.step = 1'b0;
    case (state)
      edt_pkg::ST_IDLE: begin
        yr_ctl.init = accept;
      end
      edt_pkg::ST_DAYS: begin
        operand = 32'(edt_pkg::SecsPerDay) << k;
      end
      edt_pkg::ST_YEAR: begin
        operand     = leap ? 32'(edt_pkg::LeapDays) : 32'(edt_pkg::CommonDays);
        yr_ctl.step = alu_res.ge;
      end
      edt_pkg::ST_MONTH: begin
        operand = {27'd0, edt_pkg::month_len(month_cnt, leap)};
      end
      edt_pkg::ST_HOUR: begin
        operand = 32'(edt_pkg::SecsPerHour) << k;
      end
      edt_pkg::ST_MINUTE: begin
        operand = 32'(edt_pkg::SecsPerMin) << k;
      end
      default: operand = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == edt_pkg::ST_MINUTE) && last_bit;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      edt_pkg::ST_IDLE: begin
        if (accept) begin
          rem <= epoch_seconds;
          k   <= 4'(edt_pkg::DayQBits - 1);
          q   <= '0;
        end
      end
      edt_pkg::ST_DAYS: begin
        q <= q_next;
        k <= k - 4'd1;
        if (last_bit) begin
          tod <= rem_next[16:0];
          rem <= {16'd0, q_next};
        end else begin
          rem <= rem_next;
        end
      end
      edt_pkg::ST_YEAR: begin
        rem       <= rem_next;
        month_cnt <= 4'd0;
      end
      edt_pkg::ST_MONTH: begin
        if (alu_res.ge && month_cnt != edt_pkg::LastMonth) begin
          rem       <= alu_res.diff;
          month_cnt <= month_cnt + 4'd1;
        end else begin
          day_work <= rem[4:0] + 5'd1;
          rem      <= {15'd0, tod};
          k        <= 4'(edt_pkg::HourQBits - 1);
          q        <= '0;
        end
      end
      edt_pkg::ST_HOUR: begin
        rem <= rem_next;
        if (last_bit) begin
          hour_work <= q_next[4:0];
          k         <= 4'(edt_pkg::MinQBits - 1);
          q         <= '0;
        end else begin
          q <= q_next;
          k <= k - 4'd1;
        end
      end
      edt_pkg::ST_MINUTE: begin
        rem <= rem_next;
        q   <= q_next;
        k   <= k - 4'd1;
        if (last_bit) begin
          day_of_month     <= day_work;
          month_number     <= month_cnt + 4'd1;
          year_number      <= year;
          hour_of_day      <= hour_work;
          minute_of_hour   <= q_next[5:0];
          second_of_minute <= rem_next[5:0];
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a result only appears once the sequencer is back at idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted word starts the day split
  assert property (@(posedge clk) disable iff (rst) accept |=> state == edt_pkg::ST_DAYS)
    else $error("accepted word did not start");

  // month stepping never passes december
  assert property (@(posedge clk) disable iff (rst)
    state == edt_pkg::ST_MONTH |-> month_cnt <= edt_pkg::LastMonth)
    else $error("month counter out of range");

  // delivered date fields are in range
  assert property (@(posedge clk) disable iff (rst)
    done |-> day_of_month != 5'd0 && month_number != 4'd0 && month_number <= 4'd12
             && hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 && second_of_minute <= 6'd59)
    else $error("result field out of range");
`endif

endmodule

>>> tb/sv/tb_epoch_seconds_to_date_time_unit.sv
module tb_epoch_seconds_to_date_time_unit;

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned RandomWords  = 400;
  localparam int unsigned DirectedRows = 17;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_time_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    date_time_t  want;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] epoch_seconds;
  logic        busy;
  logic        done;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [11:0] year_number;
  logic [4:0]  hour_of_day;
  logic [5:0]  minute_of_hour;
  logic [5:0]  second_of_minute;

  date_time_t    expected_dates [$];
  date_time_t    oldest_date;
  directed_row_t directed_rows [DirectedRows];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   sender_idle_pct;

  epoch_seconds_to_date_time_unit u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .epoch_seconds    (epoch_seconds),
    .busy             (busy),
    .done             (done),
    .day_of_month     (day_of_month),
    .month_number     (month_number),
    .year_number      (year_number),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gregorian leap rule
  function automatic logic leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  // days per zero-based month
  function automatic int unsigned days_in_month(input int unsigned mon, input logic leap);
    int unsigned len;
    case (mon)
      1:           len = leap ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // calendar date and time of day for one word
  function automatic date_time_t calendar_of(input logic [31:0] secs);
    int unsigned days_left;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    date_time_t  dt;
    days_left = secs / edt_pkg::SecsPerDay;
    tod       = secs % edt_pkg::SecsPerDay;
    yr        = edt_pkg::FirstYear;
    while (days_left >= (leap_year(yr) ? edt_pkg::LeapDays : edt_pkg::CommonDays)) begin
      days_left -= leap_year(yr) ? edt_pkg::LeapDays : edt_pkg::CommonDays;
      yr++;
    end
    // december never steps, so the last day of the year stays in month 12
    mon = 0;
    while (mon < 11) begin
      mlen = days_in_month(mon, leap_year(yr));
      if (days_left < mlen) break;
      days_left -= mlen;
      mon++;
    end
    dt.day    = 5'(days_left + 1);
    dt.month  = 4'(mon + 1);
    dt.year   = 12'(yr);
    dt.hour   = 5'(tod / edt_pkg::SecsPerHour);
    dt.minute = 6'((tod % edt_pkg::SecsPerHour) / edt_pkg::SecsPerMin);
    dt.second = 6'(tod % edt_pkg::SecsPerMin);
    return dt;
  endfunction

  // field compare
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // offer one word, sometimes after a random gap, and queue its result once taken
  task automatic send_word(input logic [31:0] secs, input date_time_t want);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 200);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_dates.insert(expected_dates.size(), want);
  endtask

  // result checker, done marks a word for exactly one cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        $display("%0t: result with no word pending, expected none, %s %0d-%0d-%0d %0d:%0d:%0d",
                 $time, "actual", year_number, month_number, day_of_month,
                 hour_of_day, minute_of_hour, second_of_minute);
        fail_count++;
      end else begin
        oldest_date = expected_dates.pop_front();
        check_field("day_of_month", 32'(oldest_date.day), 32'(day_of_month));
        check_field("month_number", 32'(oldest_date.month), 32'(month_number));
        check_field("year_number", 32'(oldest_date.year), 32'(year_number));
        check_field("hour_of_day", 32'(oldest_date.hour), 32'(hour_of_day));
        check_field("minute_of_hour", 32'(oldest_date.minute), 32'(minute_of_hour));
        check_field("second_of_minute", 32'(oldest_date.second), 32'(second_of_minute));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus
  initial begin
    longint unsigned wide;
    logic [31:0]     word;
    int unsigned     kind;
    int unsigned     yr;
    int unsigned     y;
    int unsigned     days;
    int unsigned     phase;
    int unsigned     n;

    sender_idle_pct = 7;
    rst             = 1'b1;
    start           = 1'b0;
    epoch_seconds   = 32'd0;

    // typed rows: epoch start, top of range, day, minute, hour and year edges
    directed_rows = '{
      '{32'd0,          1'b1, '{5'd1,  4'd1,  12'd1970, 5'd0,  6'd0,  6'd0}},
      '{32'hFFFF_FFFF,  1'b1, '{5'd7,  4'd2,  12'd2106, 5'd6,  6'd28, 6'd15}},
      '{32'd59,         1'b1, '{5'd1,  4'd1,  12'd1970, 5'd0,  6'd0,  6'd59}},
      '{32'd3599,       1'b1, '{5'd1,  4'd1,  12'd1970, 5'd0,  6'd59, 6'd59}},
      '{32'd86399,      1'b1, '{5'd1,  4'd1,  12'd1970, 5'd23, 6'd59, 6'd59}},
      '{32'd86400,      1'b1, '{5'd2,  4'd1,  12'd1970, 5'd0,  6'd0,  6'd0}},
      '{32'd31535999,   1'b1, '{5'd31, 4'd12, 12'd1970, 5'd23, 6'd59, 6'd59}},
      '{32'd31536000,   1'b1, '{5'd1,  4'd1,  12'd1971, 5'd0,  6'd0,  6'd0}},
      // leap days, last day of a leap year, century years and bit patterns
      '{32'd68169600,   1'b0, '0},
      '{32'd951782400,  1'b0, '0},
      '{32'd978220800,  1'b0, '0},
      '{32'd946684799,  1'b0, '0},
      '{32'd4107542399, 1'b0, '0},
      '{32'd4294944000, 1'b0, '0},
      '{32'h8000_0000,  1'b0, '0},
      '{32'h5555_5555,  1'b0, '0},
      '{32'hAAAA_AAAA,  1'b0, '0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    for (n = 0; n < DirectedRows; n++) begin
      send_word(directed_rows[n].secs,
                directed_rows[n].typed ? directed_rows[n].want
                                       : calendar_of(directed_rows[n].secs));
    end

    // random words in three idle phases
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 56 : 0;
      for (n = 0; n < RandomWords / 3; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          word = $urandom();
        end else if (kind < 8) begin
          // near a new year, a leap day or a midnight
          yr   = $urandom_range(edt_pkg::FirstYear, 2106);
          days = 0;
          for (y = edt_pkg::FirstYear; y < yr; y++) begin
            days += leap_year(y) ? edt_pkg::LeapDays : edt_pkg::CommonDays;
          end
          case ($urandom_range(0, 3))
            0:       if (days > 0) days = days - 1;
            1:       days = days;
            2:       days = days + $urandom_range(58, 60);
            default: days = days + $urandom_range(0, 365);
          endcase
          wide = longint'(days) * edt_pkg::SecsPerDay;
          case ($urandom_range(0, 2))
            0:       wide = wide;
            1:       wide = wide + edt_pkg::SecsPerDay - 1;
            default: wide = wide + $urandom_range(0, edt_pkg::SecsPerDay - 1);
          endcase
          word = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
        end else if (kind == 8) begin
          word = $urandom_range(0, 100000000);
        end else begin
          word = 32'hFFFF_FFFF - $urandom_range(0, 100000000);
        end
        send_word(word, calendar_of(word));
      end
    end

    start <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
